### rtl/uhts_pkg.sv
// ----------------------------------------------------------------------------
// uhts_pkg
// Types, action codes and helpers shared by the transfer sequencer files.
// ----------------------------------------------------------------------------
package uhts_pkg;

    localparam logic [3:0] ACT_CONFIG     = 4'd0;
    localparam logic [3:0] ACT_SETUP      = 4'd1;
    localparam logic [3:0] ACT_REQ_IN     = 4'd2;
    localparam logic [3:0] ACT_SEND_OUT   = 4'd3;
    localparam logic [3:0] ACT_READ       = 4'd4;
    localparam logic [3:0] ACT_STATUS_IN  = 4'd5;
    localparam logic [3:0] ACT_STATUS_OUT = 4'd6;
    localparam logic [3:0] ACT_SET_ADDR   = 4'd7;
    localparam logic [3:0] ACT_DONE       = 4'd8;
    localparam logic [3:0] ACT_FAIL       = 4'd9;

    localparam logic [7:0] REQ_TYPE_STD_DEV = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS  = 8'h05;
    localparam logic [7:0] ADDR_MASK        = 8'hFF;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SETUP  = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_STATUS = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic        is_control;
        logic        is_in;
        logic [9:0]  max_packet;
        logic [15:0] total_length;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic        error_seen;
        logic [9:0]  received_count;
    } req_item_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] byte_offset;
        logic [9:0]  byte_count;
        logic [15:0] bytes_done;
        logic [7:0]  new_address;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic push;
        logic push_two;
    } push_ctl_t;

    function automatic rsp_item_t make_rsp(
        input logic [3:0]  action,
        input logic [15:0] offset,
        input logic [9:0]  count,
        input logic [15:0] done,
        input logic [7:0]  addr,
        input logic        last
    );
        rsp_item_t r;
        r.action      = action;
        r.byte_offset = offset;
        r.byte_count  = count;
        r.bytes_done  = done;
        r.new_address = addr;
        r.last        = last;
        return r;
    endfunction

    function automatic logic [9:0] pkt_size(input logic [9:0] limit, input logic [15:0] left);
        return ({6'd0, limit} < left) ? limit : left[9:0];
    endfunction

endpackage

### rtl/uhts_req_if.sv
// ----------------------------------------------------------------------------
// uhts_req_if
// Request channel: start and completion event items.
// ----------------------------------------------------------------------------
interface uhts_req_if;
    import uhts_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/uhts_rsp_if.sv
// ----------------------------------------------------------------------------
// uhts_rsp_if
// Response channel: action items.
// ----------------------------------------------------------------------------
interface uhts_rsp_if;
    import uhts_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/uhts_result_fifo.sv
// ----------------------------------------------------------------------------
// uhts_result_fifo
// Result queue: takes one or two items per cycle, hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module uhts_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uhts_pkg::push_ctl_t  push_ctl,
    input  uhts_pkg::rsp_item_t  wr_data0,
    input  uhts_pkg::rsp_item_t  wr_data1,
    output logic                 space_ok,
    uhts_rsp_if.source           rsp
);
    import uhts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsp_item_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [AW-1:0]   wr_ptr_inc;
    logic            pop;

    assign pop        = rsp.valid && rsp.ready;
    assign wr_ptr_inc = AW'(wr_ptr_reg + 1'b1);
    assign space_ok   = (count_reg <= CW'(DEPTH - 2));
    assign rsp.valid  = (count_reg != '0);
    assign rsp.data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ctl.push)
        begin
            wr_ptr_next = push_ctl.push_two ? AW'(wr_ptr_reg + 2'd2) : wr_ptr_inc;
            count_next  = CW'(count_next + (push_ctl.push_two ? 2'd2 : 2'd1));
        end
        if (pop)
        begin
            rd_ptr_next = AW'(rd_ptr_reg + 1'b1);
            count_next  = CW'(count_next - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ctl.push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
            if (push_ctl.push_two)
            begin
                mem_reg[wr_ptr_inc] <= wr_data1;
            end
        end
    end

endmodule

### rtl/usb_host_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// usb_host_transfer_sequencer_core
// Drives one USB host transfer packet by packet. A start item loads a
// control or bulk/interrupt transfer; each completion event advances it
// through setup, data and status stages and yields one or two action items.
// A request item is taken in the cycle it is offered whenever the result
// queue has room for two entries, and its actions are in the queue in the
// following cycle. The result port delivers one action per cycle while
// the consumer is ready, so an item that yields two actions holds the
// port for both (read fifo with the next step, configure with the first
// packet, set address with done). RESULT_DEPTH sets the queue size and
// must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module usb_host_transfer_sequencer_core #(
    parameter int RESULT_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    uhts_req_if.sink  req,
    uhts_rsp_if.source rsp
);
    import uhts_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic        control_reg,   control_next;
    logic        dir_in_reg,    dir_in_next;
    logic [9:0]  limit_reg,     limit_next;
    logic [15:0] wanted_reg,    wanted_next;
    logic [15:0] done_reg,      done_next;
    logic [9:0]  cur_reg,       cur_next;
    logic        addr_pend_reg, addr_pend_next;
    logic [7:0]  addr_val_reg,  addr_val_next;

    logic        accept;
    logic        space_ok;
    push_ctl_t   push_ctl;
    rsp_item_t   res0;
    rsp_item_t   res1;
    logic        two;

    logic [9:0]  clamp_size;
    logic        rd_active;
    logic [9:0]  size_eff;
    logic [15:0] done_new;
    logic        finish;
    logic [9:0]  next_size;
    logic [9:0]  start_size;
    logic [9:0]  setup_size;
    logic [3:0]  pkt_act;
    logic [3:0]  status_act;
    rsp_item_t   tail_res;

    assign req.ready = space_ok;
    assign accept    = req.valid && req.ready;

    assign pkt_act    = dir_in_reg ? ACT_REQ_IN : ACT_SEND_OUT;
    assign status_act = dir_in_reg ? ACT_STATUS_OUT : ACT_STATUS_IN;

    assign clamp_size = (req.data.received_count > cur_reg) ? cur_reg
                                                             : req.data.received_count;
    assign rd_active  = dir_in_reg && (cur_reg != '0);
    assign size_eff   = rd_active ? clamp_size : cur_reg;
    assign done_new   = done_reg + {6'd0, size_eff};
    assign finish     = (dir_in_reg && (size_eff < limit_reg)) || (done_new >= wanted_reg);
    assign next_size  = pkt_size(limit_reg, wanted_reg - done_new);
    assign start_size = pkt_size(req.data.max_packet, req.data.total_length);
    assign setup_size = pkt_size(limit_reg, wanted_reg - done_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        control_next   = control_reg;
        dir_in_next    = dir_in_reg;
        limit_next     = limit_reg;
        wanted_next    = wanted_reg;
        done_next      = done_reg;
        cur_next       = cur_reg;
        addr_pend_next = addr_pend_reg;
        addr_val_next  = addr_val_reg;
        two            = 1'b0;
        res0           = make_rsp(ACT_FAIL, '0, '0, done_reg, '0, 1'b1);
        res1           = make_rsp(ACT_DONE, '0, '0, done_reg, '0, 1'b1);
        tail_res       = make_rsp(ACT_DONE, '0, '0, done_new, '0, 1'b1);

        priority if (req.data.kind == KIND_START)
        begin
            control_next   = req.data.is_control;
            dir_in_next    = req.data.is_in;
            limit_next     = req.data.max_packet;
            wanted_next    = req.data.total_length;
            done_next      = '0;
            cur_next       = '0;
            addr_pend_next = req.data.is_control
                             && (req.data.request_type == REQ_TYPE_STD_DEV)
                             && (req.data.request_code == REQ_SET_ADDRESS);
            addr_val_next  = req.data.request_value[7:0] & ADDR_MASK;
            if (req.data.is_control)
            begin
                phase_next = PH_SETUP;
                res0       = make_rsp(ACT_SETUP, '0, '0, '0, '0, 1'b1);
            end
            else
            begin
                phase_next = PH_DATA;
                cur_next   = start_size;
                two        = 1'b1;
                res0       = make_rsp(ACT_CONFIG, '0, req.data.max_packet, '0, '0, 1'b0);
                res1       = make_rsp(req.data.is_in ? ACT_REQ_IN : ACT_SEND_OUT,
                                      '0, start_size, '0, '0, 1'b1);
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            res0 = make_rsp(ACT_FAIL, '0, '0, done_reg, '0, 1'b1);
        end
        else if (req.data.error_seen)
        begin
            phase_next = PH_IDLE;
            res0       = make_rsp(ACT_FAIL, '0, '0, done_reg, '0, 1'b1);
        end
        else
        begin
            unique case (phase_reg)
                PH_SETUP:
                begin
                    if (done_reg >= wanted_reg)
                    begin
                        phase_next = PH_STATUS;
                        res0       = make_rsp(status_act, '0, '0, done_reg, '0, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        cur_next   = setup_size;
                        res0       = make_rsp(pkt_act, done_reg, setup_size, done_reg,
                                              '0, 1'b1);
                    end
                end
                PH_DATA:
                begin
                    done_next = done_new;
                    cur_next  = size_eff;
                    if (finish)
                    begin
                        if (control_reg)
                        begin
                            phase_next = PH_STATUS;
                            tail_res   = make_rsp(status_act, '0, '0, done_new, '0, 1'b1);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            tail_res   = make_rsp(ACT_DONE, '0, '0, done_new, '0, 1'b1);
                        end
                    end
                    else
                    begin
                        cur_next = next_size;
                        tail_res = make_rsp(pkt_act, done_new, next_size, done_new,
                                            '0, 1'b1);
                    end
                    if (rd_active && (clamp_size != '0))
                    begin
                        two  = 1'b1;
                        res0 = make_rsp(ACT_READ, done_reg, clamp_size, done_reg,
                                        '0, 1'b0);
                        res1 = tail_res;
                    end
                    else
                    begin
                        res0 = tail_res;
                    end
                end
                PH_STATUS:
                begin
                    phase_next = PH_IDLE;
                    if (addr_pend_reg)
                    begin
                        two  = 1'b1;
                        res0 = make_rsp(ACT_SET_ADDR, '0, '0, done_reg, addr_val_reg,
                                        1'b0);
                        res1 = make_rsp(ACT_DONE, '0, '0, done_reg, '0, 1'b1);
                    end
                    else
                    begin
                        res0 = make_rsp(ACT_DONE, '0, '0, done_reg, '0, 1'b1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    res0       = make_rsp(ACT_FAIL, '0, '0, done_reg, '0, 1'b1);
                end
            endcase
        end
    end

    assign push_ctl.push     = accept;
    assign push_ctl.push_two = accept && two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            control_reg   <= 1'b0;
            dir_in_reg    <= 1'b0;
            limit_reg     <= '0;
            wanted_reg    <= '0;
            done_reg      <= '0;
            cur_reg       <= '0;
            addr_pend_reg <= 1'b0;
            addr_val_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            control_reg   <= control_next;
            dir_in_reg    <= dir_in_next;
            limit_reg     <= limit_next;
            wanted_reg    <= wanted_next;
            done_reg      <= done_next;
            cur_reg       <= cur_next;
            addr_pend_reg <= addr_pend_next;
            addr_val_reg  <= addr_val_next;
        end
    end

    uhts_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_ctl (push_ctl),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .space_ok (space_ok),
        .rsp      (rsp)
    );

endmodule

### rtl/uhts_checker.sv
// ----------------------------------------------------------------------------
// uhts_checker
// Port-level checks for the transfer sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module uhts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input uhts_pkg::rsp_item_t rsp_data
);
    import uhts_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response item changed while stalled");

    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted item produced no result");

    a_addr_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && (rsp_data.action == ACT_SET_ADDR)
        |=> rsp_valid && (rsp_data.action == ACT_DONE) && rsp_data.last)
        else $error("set address not followed by done");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_data.action == ACT_CONFIG) || (rsp_data.action == ACT_READ)
                      || (rsp_data.action == ACT_SET_ADDR))
        |-> !rsp_data.last)
        else $error("leading action flagged last");

endmodule

bind usb_host_transfer_sequencer_core uhts_checker u_uhts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
